@@ rtl/projection_char_segmenter_defines.svh @@
// Assertion macros shared by the segmenter modules.
// Each macro expects the including module to have aclk and aresetn.
`ifndef PROJECTION_CHAR_SEGMENTER_DEFINES_SVH
`define PROJECTION_CHAR_SEGMENTER_DEFINES_SVH

`ifndef SYNTHESIS

`define PCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define PCS_ASSERT_NEVER(label, expr, msg) \
    `PCS_ASSERT(label, !(expr), msg)

`else

`define PCS_ASSERT(label, prop, msg)

`define PCS_ASSERT_NEVER(label, expr, msg)

`endif

`endif

@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

    // Default sizes of the storage.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int NUM_CHARS_DEF  = 7;

    // Configuration register widths and port format.
    localparam int IMG_W_W      = 9;
    localparam int IMG_H_W      = 7;
    localparam int ROW_THR_W    = 9;
    localparam int COL_THR_W    = 7;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_THRESHOLD = 3'd3;

    localparam logic [IMG_W_W-1:0]   IMAGE_WIDTH_RST   = 9'd256;
    localparam logic [IMG_H_W-1:0]   IMAGE_HEIGHT_RST  = 7'd64;
    localparam logic [ROW_THR_W-1:0] ROW_THRESHOLD_RST = 9'd10;
    localparam logic [COL_THR_W-1:0] COL_THRESHOLD_RST = 7'd5;

    // Payload widths.
    localparam int PIXEL_W      = 8;
    localparam int CHAR_INDEX_W = 3;
    localparam int LEFT_W       = 8;
    localparam int TOP_W        = 7;
    localparam int BOX_WIDTH_W  = 9;
    localparam int BOX_HEIGHT_W = 7;

    // Control from the sequencer to the column/row sweep.
    typedef struct packed {
        logic start;
        logic eval;
    } scan_ctl_t;

    // Status back from the sweep.
    typedef struct packed {
        logic busy;
        logic done;
        logic report;
    } scan_stat_t;

    // A size of zero acts as one, a size above the maximum acts as the maximum.
    function automatic int clamp_size(input int v, input int maxv);
        int r;
        r = v;
        if (v < 1) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

@@ rtl/projection_char_segmenter.sv @@
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_pixel, one pixel in raster order
// m_        out        m_valid / m_ready      m_char_index, m_left, m_top,
//                                             m_box_width, m_box_height, m_last
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One pixel is taken per clock while an image streams in; the column count is a
// read-modify-write of the column memory and the row count goes out at row end.
// After the last pixel the input is held off while one sweep reads both count
// memories and zeroes the column memory. The NUM_CHARS boxes then leave one per
// transfer, with the input still held off. After reset the same sweep runs once
// to clear the column memory before s_ready rises.
`include "projection_char_segmenter_defines.svh"

module projection_char_segmenter #(
    parameter int MAX_WIDTH  = pcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pcs_pkg::MAX_HEIGHT_DEF,
    parameter int NUM_CHARS  = pcs_pkg::NUM_CHARS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pcs_pkg::PIXEL_W-1:0]         s_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pcs_pkg::CHAR_INDEX_W-1:0]    m_char_index,
    output logic [pcs_pkg::LEFT_W-1:0]          m_left,
    output logic [pcs_pkg::TOP_W-1:0]           m_top,
    output logic [pcs_pkg::BOX_WIDTH_W-1:0]     m_box_width,
    output logic [pcs_pkg::BOX_HEIGHT_W-1:0]    m_box_height,
    output logic                                m_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import pcs_pkg::*;

    localparam int CAW = $clog2(MAX_WIDTH);
    localparam int RAW = $clog2(MAX_HEIGHT);
    localparam int CCW = $clog2(MAX_HEIGHT + 1);
    localparam int RCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int CIW = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;
    localparam logic [CIW-1:0] LAST_K = CIW'(NUM_CHARS - 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [IMG_W_W-1:0]     image_width_reg;
    logic [IMG_H_W-1:0]     image_height_reg;
    logic [ROW_THR_W-1:0]   row_threshold_reg;
    logic [COL_THR_W-1:0]   col_threshold_reg;
    logic                   m_valid_reg;
    logic [CIW-1:0]         k_reg;
    logic [CHAR_INDEX_W-1:0] m_char_index_reg;
    logic [LEFT_W-1:0]      m_left_reg;
    logic [TOP_W-1:0]       m_top_reg;
    logic [BOX_WIDTH_W-1:0] m_box_width_reg;
    logic [BOX_HEIGHT_W-1:0] m_box_height_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   m_accept;
    logic                   box_load;
    logic [CIW-1:0]         box_sel;
    logic [CAW-1:0]         sel_start;
    logic [CAW-1:0]         sel_end;
    logic [BOX_WIDTH_W-1:0] sel_width;

    scan_ctl_t              scan_ctl;
    scan_stat_t             scan_stat;

    logic [CAW-1:0]         acc_col_raddr;
    logic                   acc_col_we;
    logic [CAW-1:0]         acc_col_waddr;
    logic [CCW-1:0]         acc_col_wdata;
    logic                   row_we;
    logic [RAW-1:0]         row_waddr;
    logic [RCW-1:0]         row_wdata;
    logic                   image_end;

    logic [CAW-1:0]         scn_col_raddr;
    logic                   scn_col_we;
    logic [CAW-1:0]         scn_col_waddr;
    logic [CCW-1:0]         scn_col_wdata;
    logic [RAW-1:0]         row_raddr;

    logic [CAW-1:0]         col_raddr;
    logic                   col_we;
    logic [CAW-1:0]         col_waddr;
    logic [CCW-1:0]         col_wdata;
    logic [CCW-1:0]         col_rdata;
    logic [RCW-1:0]         row_rdata;

    logic [CAW-1:0]         edge_start [NUM_CHARS];
    logic [CAW-1:0]         edge_end [NUM_CHARS];
    logic [HCW-1:0]         top_offset;
    logic [HCW-1:0]         band_height;

    assign s_ready   = (state_reg == ST_RUN);
    assign s_accept  = s_valid && s_ready;
    assign m_accept  = m_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    assign scan_ctl.start = (state_reg == ST_INIT) || (state_reg == ST_DRAIN);
    assign scan_ctl.eval  = (state_reg == ST_DRAIN);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                state_next = ST_SWEEP;
            end
            ST_RUN: begin
                if (image_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (scan_stat.report) begin
                    state_next = ST_LOAD;
                end else if (scan_stat.done) begin
                    state_next = ST_RUN;
                end
            end
            ST_LOAD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_accept && (k_reg == LAST_K)) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Boxes go into the output register in ST_LOAD and as any box but the last transfers.
    always_comb begin
        box_load  = (state_reg == ST_LOAD)
                    || ((state_reg == ST_OUT) && m_accept && (k_reg != LAST_K));
        box_sel   = (state_reg == ST_LOAD) ? '0 : k_reg + CIW'(1);
        sel_start = edge_start[box_sel];
        sel_end   = edge_end[box_sel];
        if (sel_end > sel_start) begin
            sel_width = BOX_WIDTH_W'(sel_end - sel_start);
        end else begin
            sel_width = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_INIT;
            m_valid_reg       <= 1'b0;
            k_reg             <= '0;
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
            row_threshold_reg <= ROW_THRESHOLD_RST;
            col_threshold_reg <= COL_THRESHOLD_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[IMG_H_W-1:0];
                    REG_ROW_THRESHOLD: row_threshold_reg <= cfg_data[ROW_THR_W-1:0];
                    REG_COL_THRESHOLD: col_threshold_reg <= cfg_data[COL_THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (box_load) begin
                m_valid_reg <= 1'b1;
                k_reg       <= box_sel;
            end else if (m_accept) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (box_load) begin
            m_char_index_reg <= CHAR_INDEX_W'(box_sel);
            m_left_reg       <= LEFT_W'(sel_start);
            m_top_reg        <= TOP_W'(top_offset);
            m_box_width_reg  <= sel_width;
            m_box_height_reg <= BOX_HEIGHT_W'(band_height);
            m_last_reg       <= (box_sel == LAST_K);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_char_index = m_char_index_reg;
    assign m_left       = m_left_reg;
    assign m_top        = m_top_reg;
    assign m_box_width  = m_box_width_reg;
    assign m_box_height = m_box_height_reg;
    assign m_last       = m_last_reg;

    // The sweep owns the column memory while it runs.
    always_comb begin
        if (scan_stat.busy) begin
            col_raddr = scn_col_raddr;
            col_we    = scn_col_we;
            col_waddr = scn_col_waddr;
            col_wdata = scn_col_wdata;
        end else begin
            col_raddr = acc_col_raddr;
            col_we    = acc_col_we;
            col_waddr = acc_col_waddr;
            col_wdata = acc_col_wdata;
        end
    end

    pcs_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .pixel        (s_pixel),
        .flush        (scan_ctl.start),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .col_raddr    (acc_col_raddr),
        .col_we       (acc_col_we),
        .col_waddr    (acc_col_waddr),
        .col_wdata    (acc_col_wdata),
        .col_rdata    (col_rdata),
        .row_we       (row_we),
        .row_waddr    (row_waddr),
        .row_wdata    (row_wdata),
        .image_end    (image_end)
    );

    pcs_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .NUM_CHARS  (NUM_CHARS)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (scan_ctl),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .row_threshold (row_threshold_reg),
        .col_threshold (col_threshold_reg),
        .col_raddr     (scn_col_raddr),
        .col_we        (scn_col_we),
        .col_waddr     (scn_col_waddr),
        .col_wdata     (scn_col_wdata),
        .col_rdata     (col_rdata),
        .row_raddr     (row_raddr),
        .row_rdata     (row_rdata),
        .edge_start    (edge_start),
        .edge_end      (edge_end),
        .top_offset    (top_offset),
        .band_height   (band_height),
        .stat          (scan_stat)
    );

    pcs_ram #(
        .WIDTH (CCW),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    pcs_ram #(
        .WIDTH (RCW),
        .DEPTH (MAX_HEIGHT)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    `PCS_ASSERT_NEVER(a_no_input_during_sweep, scan_stat.busy && s_ready, "pixel input open while the sweep runs")
    `PCS_ASSERT(a_result_only_in_output, m_valid |-> (state_reg == ST_OUT), "result shown outside the output phase")

endmodule

@@ rtl/pcs_ram.sv @@
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read of the entry being written returns the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pcs_accum.sv @@
`include "projection_char_segmenter_defines.svh"

module pcs_accum #(
    parameter int MAX_WIDTH  = pcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pcs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [pcs_pkg::PIXEL_W-1:0]       pixel,
    input  logic                              flush,
    input  logic [pcs_pkg::IMG_W_W-1:0]       image_width,
    input  logic [pcs_pkg::IMG_H_W-1:0]       image_height,
    output logic [$clog2(MAX_WIDTH)-1:0]      col_raddr,
    output logic                              col_we,
    output logic [$clog2(MAX_WIDTH)-1:0]      col_waddr,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]   col_wdata,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   col_rdata,
    output logic                              row_we,
    output logic [$clog2(MAX_HEIGHT)-1:0]     row_waddr,
    output logic [$clog2(MAX_WIDTH+1)-1:0]    row_wdata,
    output logic                              image_end
);

    import pcs_pkg::*;

    localparam int CAW = $clog2(MAX_WIDTH);
    localparam int RAW = $clog2(MAX_HEIGHT);
    localparam int CCW = $clog2(MAX_HEIGHT + 1);
    localparam int RCW = $clog2(MAX_WIDTH + 1);

    logic [CAW-1:0] col_pos_reg;
    logic [RAW-1:0] row_pos_reg;
    logic [RCW-1:0] row_acc_reg;
    logic           s1_valid_reg;
    logic [CAW-1:0] s1_addr_reg;
    logic           s1_fg_reg;
    logic           lw_valid_reg;
    logic [CAW-1:0] lw_addr_reg;
    logic [CCW-1:0] lw_data_reg;

    logic           fg;
    logic           col_last;
    logic           row_last;
    logic [RCW-1:0] row_sum;
    logic [CCW-1:0] col_base;
    logic [CCW-1:0] col_sum;
    int             w_int;
    int             h_int;

    always_comb begin
        w_int    = clamp_size(int'(image_width), MAX_WIDTH);
        h_int    = clamp_size(int'(image_height), MAX_HEIGHT);
        fg       = |pixel;
        col_last = (int'(col_pos_reg) + 1) >= w_int;
        row_last = (int'(row_pos_reg) + 1) >= h_int;
        row_sum  = row_acc_reg + RCW'(fg);

        // The last write to an entry is its current value; this covers a
        // read that was issued in the same cycle as the write.
        if (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) begin
            col_base = lw_data_reg;
        end else begin
            col_base = col_rdata;
        end
        col_sum = col_base + CCW'(s1_fg_reg);
    end

    assign col_raddr = col_pos_reg;
    assign col_we    = s1_valid_reg;
    assign col_waddr = s1_addr_reg;
    assign col_wdata = col_sum;
    assign row_we    = accept && col_last;
    assign row_waddr = row_pos_reg;
    assign row_wdata = row_sum;
    assign image_end = accept && col_last && row_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            row_acc_reg  <= '0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (flush) begin
                lw_valid_reg <= 1'b0;
            end else if (s1_valid_reg) begin
                lw_valid_reg <= 1'b1;
            end
            if (accept) begin
                if (col_last) begin
                    col_pos_reg <= '0;
                    row_acc_reg <= '0;
                    if (row_last) begin
                        row_pos_reg <= '0;
                    end else begin
                        row_pos_reg <= row_pos_reg + RAW'(1);
                    end
                end else begin
                    col_pos_reg <= col_pos_reg + CAW'(1);
                    row_acc_reg <= row_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= col_pos_reg;
            s1_fg_reg   <= fg;
        end
        if (s1_valid_reg) begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= col_sum;
        end
    end

    `PCS_ASSERT(a_end_restarts_raster, image_end |=> (col_pos_reg == '0 && row_pos_reg == '0), "raster position not cleared after image end")
    `PCS_ASSERT(a_write_follows_read, accept |=> (col_we && col_waddr == $past(col_pos_reg)), "column write-back lost its address")

endmodule

@@ rtl/pcs_scan.sv @@
`include "projection_char_segmenter_defines.svh"

module pcs_scan #(
    parameter int MAX_WIDTH  = pcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pcs_pkg::MAX_HEIGHT_DEF,
    parameter int NUM_CHARS  = pcs_pkg::NUM_CHARS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pcs_pkg::scan_ctl_t                ctl,
    input  logic [pcs_pkg::IMG_W_W-1:0]       image_width,
    input  logic [pcs_pkg::IMG_H_W-1:0]       image_height,
    input  logic [pcs_pkg::ROW_THR_W-1:0]     row_threshold,
    input  logic [pcs_pkg::COL_THR_W-1:0]     col_threshold,
    output logic [$clog2(MAX_WIDTH)-1:0]      col_raddr,
    output logic                              col_we,
    output logic [$clog2(MAX_WIDTH)-1:0]      col_waddr,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]   col_wdata,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   col_rdata,
    output logic [$clog2(MAX_HEIGHT)-1:0]     row_raddr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    row_rdata,
    output logic [$clog2(MAX_WIDTH)-1:0]      edge_start [NUM_CHARS],
    output logic [$clog2(MAX_WIDTH)-1:0]      edge_end [NUM_CHARS],
    output logic [$clog2(MAX_HEIGHT+1)-1:0]   top_offset,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]   band_height,
    output pcs_pkg::scan_stat_t               stat
);

    import pcs_pkg::*;

    localparam int CAW       = $clog2(MAX_WIDTH);
    localparam int RAW       = $clog2(MAX_HEIGHT);
    localparam int HCW       = $clog2(MAX_HEIGHT + 1);
    localparam int SWEEP_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int IW        = $clog2(SWEEP_LEN + 1);
    localparam int NUM_EDGES = 2 * NUM_CHARS;
    localparam int EW        = $clog2(NUM_EDGES + 1);
    localparam int CIW       = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;

    logic           busy_reg;
    logic           eval_reg;
    logic [IW-1:0]  idx_reg;
    logic           p_valid_reg;
    logic [IW-1:0]  p_idx_reg;
    logic [EW-1:0]  ecnt_reg;
    logic           inside_reg;
    logic [HCW-1:0] top_reg;
    logic [HCW-1:0] band_reg;
    logic [CAW-1:0] start_reg [NUM_CHARS];
    logic [CAW-1:0] end_reg [NUM_CHARS];

    logic           issue;
    logic           last_p;
    logic           col_live;
    logic           row_live;
    logic           rise;
    logic           fall;
    logic [CIW-1:0] pair_sel;
    int             w_int;
    int             h_int;

    always_comb begin
        w_int    = clamp_size(int'(image_width), MAX_WIDTH);
        h_int    = clamp_size(int'(image_height), MAX_HEIGHT);
        issue    = busy_reg && (int'(idx_reg) < SWEEP_LEN);
        last_p   = p_valid_reg && (int'(p_idx_reg) == SWEEP_LEN - 1);
        col_live = eval_reg && p_valid_reg && (int'(p_idx_reg) < w_int)
                   && (int'(ecnt_reg) < NUM_EDGES);
        row_live = eval_reg && p_valid_reg && (int'(p_idx_reg) < h_int);
        rise     = col_live && !inside_reg
                   && (int'(col_rdata) > int'(col_threshold));
        fall     = col_live && inside_reg
                   && (int'(col_rdata) < int'(col_threshold));
        pair_sel = CIW'(ecnt_reg >> 1);
    end

    // Every column is read once and written back as zero in the cycle after its read,
    // which also leaves the column memory clear for the next image.
    assign col_raddr   = CAW'(idx_reg);
    assign row_raddr   = RAW'(idx_reg);
    assign col_we      = p_valid_reg && (int'(p_idx_reg) < MAX_WIDTH);
    assign col_waddr   = CAW'(p_idx_reg);
    assign col_wdata   = '0;
    assign edge_start  = start_reg;
    assign edge_end    = end_reg;
    assign top_offset  = top_reg;
    assign band_height = band_reg;
    assign stat.busy   = busy_reg;
    assign stat.done   = last_p;
    assign stat.report = last_p && eval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            eval_reg    <= 1'b0;
            idx_reg     <= '0;
            p_valid_reg <= 1'b0;
            ecnt_reg    <= '0;
            inside_reg  <= 1'b0;
        end else begin
            p_valid_reg <= issue;
            if (ctl.start) begin
                busy_reg   <= 1'b1;
                eval_reg   <= ctl.eval;
                idx_reg    <= '0;
                ecnt_reg   <= '0;
                inside_reg <= 1'b0;
            end else begin
                if (last_p) begin
                    busy_reg <= 1'b0;
                end
                if (issue) begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (rise || fall) begin
                    ecnt_reg   <= ecnt_reg + EW'(1);
                    inside_reg <= rise;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg <= idx_reg;
        if (ctl.start) begin
            top_reg  <= '0;
            band_reg <= '0;
            for (int i = 0; i < NUM_CHARS; i++) begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end else begin
            if (rise) begin
                start_reg[pair_sel] <= CAW'(p_idx_reg);
            end
            if (fall) begin
                end_reg[pair_sel] <= CAW'(p_idx_reg);
            end
            if (row_live) begin
                if (int'(row_rdata) > int'(row_threshold)) begin
                    band_reg <= band_reg + HCW'(1);
                end
                if ((int'(p_idx_reg) <= (h_int >> 1))
                        && (int'(row_rdata) < int'(row_threshold))) begin
                    top_reg <= top_reg + HCW'(1);
                end
            end
        end
    end

    `PCS_ASSERT(a_inside_tracks_parity, busy_reg |-> (inside_reg == ecnt_reg[0]), "character flag out of step with edge count")
    `PCS_ASSERT(a_done_only_when_busy, stat.done |-> busy_reg, "sweep finished while idle")

endmodule

@@ tb/tb_projection_char_segmenter.sv @@
module tb_projection_char_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    import pcs_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int NUM_CHARS     = NUM_CHARS_DEF;
    localparam int NUM_EDGES     = 2 * NUM_CHARS;
    localparam int CLK_HALF      = 2;
    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 50;
    localparam int MAX_PIXELS    = 64;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Two rows of eight pixels; together they set every pixel bit.
    localparam logic [16*PIXEL_W-1:0] TWO_ROW_PATTERN = {
        8'd255, 8'd1, 8'd0, 8'd0,  8'd128, 8'd64, 8'd0, 8'd2,
        8'd4,   8'd8, 8'd0, 8'd16, 8'd32,  8'd0,  8'd0, 8'd0
    };

    typedef struct packed {
        logic [CHAR_INDEX_W-1:0] char_index;
        logic [LEFT_W-1:0]       left;
        logic [TOP_W-1:0]        top;
        logic [BOX_WIDTH_W-1:0]  box_width;
        logic [BOX_HEIGHT_W-1:0] box_height;
        logic                    last;
    } char_box_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [PIXEL_W-1:0]      s_pixel = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [CHAR_INDEX_W-1:0] m_char_index;
    logic [LEFT_W-1:0]       m_left;
    logic [TOP_W-1:0]        m_top;
    logic [BOX_WIDTH_W-1:0]  m_box_width;
    logic [BOX_HEIGHT_W-1:0] m_box_height;
    logic                    m_last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    projection_char_segmenter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_index (m_char_index),
        .m_left       (m_left),
        .m_top        (m_top),
        .m_box_width  (m_box_width),
        .m_box_height (m_box_height),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Register copies as the block holds them.
    logic [IMG_W_W-1:0]   img_w_reg   = IMAGE_WIDTH_RST;
    logic [IMG_H_W-1:0]   img_h_reg   = IMAGE_HEIGHT_RST;
    logic [ROW_THR_W-1:0] row_thr_reg = ROW_THRESHOLD_RST;
    logic [COL_THR_W-1:0] col_thr_reg = COL_THRESHOLD_RST;

    // Foreground counts and raster position of the image in progress.
    bit [ROW_THR_W-1:0] row_fg_count [MAX_H];
    bit [COL_THR_W-1:0] col_fg_count [MAX_W];
    int                 scan_col;
    int                 scan_row;

    logic [PIXEL_W-1:0] pending_pixels [$];
    char_box_t          expected_boxes [$];
    char_box_t          box_want;
    int                 pixels_queued;
    int                 errors;
    bit                 pixel_taken;
    bit                 steady;
    bit                 pressure_armed;
    bit                 pressure_done;
    int                 hold_left;

    always #CLK_HALF aclk = ~aclk;

    function automatic int dim_used(input int v, input int maxv);
        return (v == 0) ? 1 : ((v > maxv) ? maxv : v);
    endfunction

    task automatic segment_pixel(input logic [PIXEL_W-1:0] pix);
        int        w, h, half, n_edges, i, k, top_rows, band_rows;
        bit        in_char;
        int        edge_col [NUM_EDGES];
        char_box_t box;
        w = dim_used(img_w_reg, MAX_W);
        h = dim_used(img_h_reg, MAX_H);
        if (pix != 0) begin
            row_fg_count[scan_row]++;
            col_fg_count[scan_col]++;
        end
        // A shrunken size ends the row or the image on the current pixel.
        if (scan_col + 1 < w) begin
            scan_col++;
        end else begin
            scan_col = 0;
            if (scan_row + 1 < h) begin
                scan_row++;
            end else begin
                half = h / 2;
                top_rows = 0;
                band_rows = 0;
                for (i = 0; i < h; i++) begin
                    if (row_fg_count[i] > row_thr_reg) band_rows++;
                    if (i <= half && row_fg_count[i] < row_thr_reg) top_rows++;
                end
                for (i = 0; i < NUM_EDGES; i++) edge_col[i] = 0;
                n_edges = 0;
                in_char = 1'b0;
                for (i = 0; i < w && n_edges < NUM_EDGES; i++) begin
                    if (col_fg_count[i] > col_thr_reg && !in_char) begin
                        edge_col[n_edges] = i;
                        n_edges++;
                        in_char = 1'b1;
                    end else if (col_fg_count[i] < col_thr_reg && in_char) begin
                        edge_col[n_edges] = i;
                        n_edges++;
                        in_char = 1'b0;
                    end
                end
                // Edges never found stay at column zero.
                for (k = 0; k < NUM_CHARS; k++) begin
                    box.char_index = k;
                    box.left       = edge_col[2*k];
                    box.top        = top_rows;
                    box.box_height = band_rows;
                    box.box_width  = (edge_col[2*k+1] > edge_col[2*k]) ?
                                     edge_col[2*k+1] - edge_col[2*k] : 0;
                    box.last       = (k == NUM_CHARS - 1);
                    expected_boxes.push_back(box);
                end
                for (i = 0; i < MAX_H; i++) row_fg_count[i] = '0;
                for (i = 0; i < MAX_W; i++) col_fg_count[i] = '0;
                scan_row = 0;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Result side: compare each transfer, then predict from an accepted pixel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_boxes.size() == 0) begin
                errors++;
                $display("%0t: box transfer: expected none, actual index %0d",
                         $time, m_char_index);
            end else begin
                box_want = expected_boxes.pop_front();
                check_field("char_index", m_char_index, box_want.char_index);
                check_field("left",       m_left,       box_want.left);
                check_field("top",        m_top,        box_want.top);
                check_field("box_width",  m_box_width,  box_want.box_width);
                check_field("box_height", m_box_height, box_want.box_height);
                check_field("last",       m_last,       box_want.last);
            end
        end
        pixel_taken = aresetn && s_valid && s_ready;
        if (pixel_taken) segment_pixel(s_pixel);
    end

    // Pixel driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pixel_taken) begin
            if (pending_pixels.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_pixel <= pending_pixels.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off once pressure is armed.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_armed && !pressure_done && m_valid) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic push_pixel(input logic [PIXEL_W-1:0] v);
        pending_pixels.push_back(v);
        pixels_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:   img_w_reg   = data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT:  img_h_reg   = data[IMG_H_W-1:0];
            REG_ROW_THRESHOLD: row_thr_reg = data[ROW_THR_W-1:0];
            REG_COL_THRESHOLD: col_thr_reg = data[COL_THR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Characters are runs of foreground columns across most rows.
    task automatic queue_image(input int w, input int h, input int noise_pct);
        bit                 fg_col [MAX_W];
        bit                 fg_row, fg, on;
        int                 run, c, r;
        logic [PIXEL_W-1:0] pv;
        on = $urandom_range(0, 1);
        run = $urandom_range(1, 3);
        for (c = 0; c < w; c++) begin
            fg_col[c] = on;
            run = run - 1;
            if (run == 0) begin
                on = !on;
                run = $urandom_range(1, 3);
            end
        end
        for (r = 0; r < h; r++) begin
            fg_row = ($urandom_range(0, 3) != 0);
            for (c = 0; c < w; c++) begin
                fg = fg_col[c] && fg_row;
                if ($urandom_range(0, 99) < noise_pct) fg = !fg;
                pv = fg ? $urandom_range(1, 255) : 0;
                push_pixel(pv);
            end
        end
    endtask

    // The block may still be sweeping after the last pixel of a partial image.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || s_valid || expected_boxes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int                    random_start, phase, pick, w_eff, h_eff, n_img, i;
        logic [3:0]            wr;
        logic [CFG_DATA_W-1:0] v;
        wait (aresetn);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // Sizes of zero act as one: two single-pixel images.
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_ROW_THRESHOLD, 0);
        write_reg(REG_COL_THRESHOLD, 0);
        push_pixel(8'd255);
        push_pixel(8'd0);
        wait_idle();

        // Two characters, the remaining boxes read missing edges.
        write_reg(REG_IMAGE_WIDTH, 8);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_ROW_THRESHOLD, 2);
        write_reg(REG_COL_THRESHOLD, 1);
        for (i = 0; i < 16; i++) push_pixel(TWO_ROW_PATTERN[PIXEL_W*(15-i) +: PIXEL_W]);
        wait_idle();

        // A start edge with no end edge gives an end left of the start.
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_ROW_THRESHOLD, 256);
        write_reg(REG_COL_THRESHOLD, 0);
        push_pixel(8'd0);
        push_pixel(8'd9);
        push_pixel(8'd9);
        push_pixel(8'd0);
        wait_idle();

        // Width and then height shrink below the position mid-image.
        write_reg(REG_IMAGE_WIDTH, 6);
        write_reg(REG_IMAGE_HEIGHT, 3);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd77);
        push_pixel(8'd255);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 2);
        push_pixel(8'd255);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_pixel(8'd3);
        push_pixel(8'd0);
        wait_idle();

        // Oversized settings act as the maximum; thresholds at their top.
        // The full-width row streams with no idling on either side.
        write_reg(REG_IMAGE_WIDTH, 511);
        write_reg(REG_ROW_THRESHOLD, 511);
        write_reg(REG_COL_THRESHOLD, 127);
        steady = 1'b1;
        queue_image(MAX_W, 1, 5);
        wait_idle();
        steady = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 127);
        write_reg(REG_ROW_THRESHOLD, 256);
        write_reg(REG_COL_THRESHOLD, 64);
        queue_image(1, MAX_H, 5);
        wait_idle();

        // Tiny images back to back while the receiver holds off.
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_ROW_THRESHOLD, 1);
        write_reg(REG_COL_THRESHOLD, 1);
        pressure_armed = 1'b1;
        repeat (6) queue_image(2, 2, 5);
        wait_idle();
        pressure_armed = 1'b0;

        random_start = pixels_queued;
        phase = 0;
        while (pixels_queued - random_start < RANDOM_ITEMS) begin
            steady = (phase >= 2 && phase < 5);
            wr = $urandom_range(1, 15);
            if (wr[0]) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    v = $urandom_range(0, 1);
                end else if (pick < 15) begin
                    v = $urandom_range(13, 40);
                end else begin
                    v = $urandom_range(2, 12);
                end
                write_reg(REG_IMAGE_WIDTH, v);
            end
            w_eff = dim_used(img_w_reg, MAX_W);
            if (wr[1]) begin
                if (w_eff <= 4 && $urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: v = 0;
                        1: v = MAX_H;
                        default: v = 127;
                    endcase
                end else begin
                    v = $urandom_range(1, 6);
                end
                write_reg(REG_IMAGE_HEIGHT, v);
            end
            h_eff = dim_used(img_h_reg, MAX_H);
            if (w_eff * h_eff > MAX_PIXELS) begin
                write_reg(REG_IMAGE_HEIGHT, 1);
                h_eff = 1;
            end
            if (wr[2]) begin
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, w_eff + 1);
                write_reg(REG_ROW_THRESHOLD, v);
            end
            if (wr[3]) begin
                v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, h_eff + 1);
                write_reg(REG_COL_THRESHOLD, v);
            end
            n_img = (w_eff * h_eff >= 16) ? 1 : $urandom_range(1, 3);
            repeat (n_img) queue_image(w_eff, h_eff, ($urandom_range(0, 7) == 0) ? 50 : 5);
            // A stray tail leaves the next image misaligned across a size change.
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 5)) push_pixel($urandom_range(0, 255));
            wait_idle();
            phase++;
        end
        steady = 1'b0;

        wait_idle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/pcs_accum.sv
rtl/pcs_scan.sv
rtl/projection_char_segmenter.sv
tb/tb_projection_char_segmenter.sv
